### rtl/core/wpba_pkg.sv
package wpba_pkg;

  localparam int unsigned WHEELS   = 4;
  localparam int unsigned WIDX_W   = 2;
  localparam int unsigned PWR_W    = 16;
  localparam int unsigned MASK_W   = 4;
  localparam int unsigned CNT_W    = 3;
  localparam int unsigned DSUM_W   = PWR_W + 2;
  localparam int unsigned TRIG_W   = PWR_W + 6;

  // shared divider: quotient always fits in PWR_W bits
  localparam int unsigned DIV_N_W  = 2 * PWR_W;
  localparam int unsigned DIV_D_W  = DSUM_W;
  localparam int unsigned QUOT_W   = PWR_W;
  localparam int unsigned STEP_W   = $clog2(QUOT_W);

  localparam logic [DIV_D_W-1:0] RSV_DIVISOR = DIV_D_W'(10);
  localparam logic [PWR_W-1:0]   PWR_LIMIT_RST = PWR_W'(960);

  // stream payload layout
  localparam int unsigned IN_DATA_W  = 152;
  localparam int unsigned MASK_LSB   = 2 * WHEELS * PWR_W;
  localparam int unsigned BUDGET_LSB = MASK_LSB + MASK_W;
  localparam int unsigned OUT_DATA_W = (WHEELS + 1) * PWR_W;

  typedef struct packed {
    logic               start;
    logic [DIV_N_W-1:0] num;
    logic [DIV_D_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [QUOT_W-1:0] quot;
  } div_rsp_t;

endpackage

### rtl/core/wpba_div.sv
module wpba_div import wpba_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  div_req_t req_i,
  output div_rsp_t rsp_o
);

  logic               busy_q;
  logic               done_q;
  logic [STEP_W-1:0]  step_q;
  logic [DIV_D_W-1:0] rem_q;
  logic [QUOT_W-1:0]  low_q;
  logic [DIV_D_W-1:0] den_q;

  logic [DIV_D_W:0]   trial;
  logic               ge;
  logic [DIV_D_W:0]   diff;

  // restoring step: remaining numerator bits leave the top of low_q,
  // quotient bits enter at the bottom
  assign trial = {rem_q, low_q[QUOT_W-1]};
  assign ge    = trial >= {1'b0, den_q};
  assign diff  = trial - {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
      rem_q  <= '0;
      low_q  <= '0;
      den_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        step_q <= '0;
        rem_q  <= DIV_D_W'(req_i.num[DIV_N_W-1:QUOT_W]);
        low_q  <= req_i.num[QUOT_W-1:0];
        den_q  <= req_i.den;
      end else if (busy_q) begin
        rem_q <= ge ? diff[DIV_D_W-1:0] : trial[DIV_D_W-1:0];
        low_q <= {low_q[QUOT_W-2:0], ge};
        step_q <= step_q + STEP_W'(1);
        if (step_q == STEP_W'(QUOT_W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quot = low_q;

endmodule

### rtl/core/wheel_power_budget_allocator_unit.sv
// Splits one power budget (1/16 W units) among four wheels: an optional
// reserve of the chassis cap/10 per active wheel, then up to ROUNDS rounds
// (clamped to 1..8) of demand-proportional grants, or an equal split when the
// unmet wheels have no demand, capped at each wheel's remaining want. One beat
// in gives one beat out. The block takes one item at a time; s_axis_tready is
// low while an item is worked on. Every division runs on one shared 16-step
// restoring divider. An item with nothing to grant goes from the check state
// straight to the done state. The reserve is cut back to budget/count, with a
// second division, when cap/10 per active wheel would overrun the budget.
// Rounds stop once the budget is spent, no wheel is unmet or a round grants
// nothing. A result waits in the output register while the next item is
// accepted; the block then holds its finished result until that register
// drains.
module wheel_power_budget_allocator_unit import wpba_pkg::*; #(
  parameter int unsigned ROUNDS = 4
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [PWR_W-1:0]      cfg_wdata_i,   // chassis power cap
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // wheel_demand_0..3, want_power_0..3, active_mask, total_budget, zero pad
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // limit_power_0..3, leftover_budget
  output logic [OUT_DATA_W-1:0] m_axis_tdata,
  output logic                  m_axis_tuser   // applied
);

  localparam int unsigned ROUNDS_C = (ROUNDS < 1) ? 1 : (ROUNDS > 8) ? 8 : ROUNDS;
  localparam int unsigned RND_W    = (ROUNDS_C > 1) ? $clog2(ROUNDS_C) : 1;

  typedef enum logic [12:0] {
    S_IDLE      = 13'b0000000000001,
    S_CHECK     = 13'b0000000000010,
    S_RSV_DIV   = 13'b0000000000100,
    S_RSV_CHK   = 13'b0000000001000,
    S_RSV_CLAMP = 13'b0000000010000,
    S_RSV_APPLY = 13'b0000000100000,
    S_ROUND     = 13'b0000001000000,
    S_WHEEL     = 13'b0000010000000,
    S_MUL       = 13'b0000100000000,
    S_SHARE_DIV = 13'b0001000000000,
    S_ROUND_END = 13'b0010000000000,
    S_DONE      = 13'b0100000000000,
    S_SPARE     = 13'b1000000000000
  } state_e;

  state_e              st_q;
  logic [PWR_W-1:0]    chassis_cap_q;
  logic [PWR_W-1:0]    dem_q  [WHEELS];
  logic [PWR_W-1:0]    want_q [WHEELS];
  logic [PWR_W-1:0]    lim_q  [WHEELS];
  logic [MASK_W-1:0]   mask_q;
  logic [PWR_W-1:0]    budget_q;
  logic                applied_q;
  logic [PWR_W-1:0]    reserve_q;
  logic [CNT_W-1:0]    cnt_q;
  logic [WIDX_W-1:0]   idx_q;
  logic [RND_W-1:0]    rnd_q;
  logic [DSUM_W-1:0]   dsum_q;
  logic [CNT_W-1:0]    unmet_q;
  logic [PWR_W:0]      total_q;
  logic [DIV_N_W-1:0]  prod_q;
  div_req_t            div_req_q;
  div_rsp_t            div_rsp;
  logic                m_valid_q;
  logic [OUT_DATA_W-1:0] m_data_q;
  logic                m_user_q;

  logic [WHEELS-1:0]   unmet_vec;
  logic [DSUM_W-1:0]   dsum_c;
  logic [CNT_W-1:0]    unmet_cnt_c;
  logic [TRIG_W-1:0]   b40_c;
  logic [TRIG_W-1:0]   p27_c;
  logic [PWR_W+CNT_W-1:0] rsv_cnt_c;
  logic [PWR_W-1:0]    rsv_g_c;
  logic [PWR_W-1:0]    room_c;
  logic [PWR_W-1:0]    grant_c;
  logic                s_hs;

  wpba_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req_q),
    .rsp_o  (div_rsp)
  );

  always_comb begin
    dsum_c = '0;
    for (int i = 0; i < WHEELS; i++) begin
      unmet_vec[i] = mask_q[i] && (want_q[i] > lim_q[i]);
      if (unmet_vec[i]) begin
        dsum_c = dsum_c + DSUM_W'(dem_q[i]);
      end
    end
  end

  assign unmet_cnt_c = CNT_W'($countones(unmet_vec));

  // budget*40 against cap*27 by shift and add
  assign b40_c = (TRIG_W'(budget_q) << 5) + (TRIG_W'(budget_q) << 3);
  assign p27_c = (TRIG_W'(chassis_cap_q) << 4) + (TRIG_W'(chassis_cap_q) << 3)
               + (TRIG_W'(chassis_cap_q) << 1) + TRIG_W'(chassis_cap_q);

  assign rsv_cnt_c = (PWR_W+CNT_W)'(reserve_q) * (PWR_W+CNT_W)'(cnt_q);
  assign rsv_g_c   = (reserve_q < want_q[idx_q]) ? reserve_q : want_q[idx_q];
  assign room_c    = want_q[idx_q] - lim_q[idx_q];
  assign grant_c   = (div_rsp.quot > room_c) ? room_c : div_rsp.quot;

  assign s_axis_tready = (st_q == S_IDLE);
  assign s_hs          = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q          <= S_IDLE;
      chassis_cap_q <= PWR_LIMIT_RST;
      for (int i = 0; i < WHEELS; i++) begin
        dem_q[i]  <= '0;
        want_q[i] <= '0;
        lim_q[i]  <= '0;
      end
      mask_q    <= '0;
      budget_q  <= '0;
      applied_q <= 1'b0;
      reserve_q <= '0;
      cnt_q     <= '0;
      idx_q     <= '0;
      rnd_q     <= '0;
      dsum_q    <= '0;
      unmet_q   <= '0;
      total_q   <= '0;
      prod_q    <= '0;
      div_req_q <= '0;
      m_valid_q <= 1'b0;
      m_data_q  <= '0;
      m_user_q  <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        chassis_cap_q <= cfg_wdata_i;
      end
      // the done state reloads the output register itself
      if (m_valid_q && m_axis_tready && st_q != S_DONE) begin
        m_valid_q <= 1'b0;
      end

      unique case (st_q)
        S_IDLE: begin
          if (s_hs) begin
            for (int i = 0; i < WHEELS; i++) begin
              dem_q[i]  <= s_axis_tdata[i*PWR_W +: PWR_W];
              want_q[i] <= s_axis_tdata[(WHEELS+i)*PWR_W +: PWR_W];
              lim_q[i]  <= '0;
            end
            mask_q   <= s_axis_tdata[MASK_LSB +: MASK_W];
            budget_q <= s_axis_tdata[BUDGET_LSB +: PWR_W];
            cnt_q    <= CNT_W'($countones(s_axis_tdata[MASK_LSB +: MASK_W]));
            st_q     <= S_CHECK;
          end
        end

        S_CHECK: begin
          rnd_q <= '0;
          if (budget_q == '0 || mask_q == '0) begin
            applied_q <= 1'b0;
            st_q      <= S_DONE;
          end else begin
            applied_q <= 1'b1;
            if (chassis_cap_q != '0 && b40_c >= p27_c) begin
              div_req_q.start <= 1'b1;
              div_req_q.num   <= DIV_N_W'(chassis_cap_q);
              div_req_q.den   <= RSV_DIVISOR;
              st_q            <= S_RSV_DIV;
            end else begin
              st_q <= S_ROUND;
            end
          end
        end

        S_RSV_DIV: begin
          div_req_q.start <= 1'b0;
          if (div_rsp.done) begin
            reserve_q <= div_rsp.quot;
            st_q      <= S_RSV_CHK;
          end
        end

        S_RSV_CHK: begin
          idx_q <= '0;
          if (rsv_cnt_c > (PWR_W+CNT_W)'(budget_q)) begin
            div_req_q.start <= 1'b1;
            div_req_q.num   <= DIV_N_W'(budget_q);
            div_req_q.den   <= DIV_D_W'(cnt_q);
            st_q            <= S_RSV_CLAMP;
          end else begin
            st_q <= S_RSV_APPLY;
          end
        end

        S_RSV_CLAMP: begin
          div_req_q.start <= 1'b0;
          if (div_rsp.done) begin
            reserve_q <= div_rsp.quot;
            st_q      <= S_RSV_APPLY;
          end
        end

        S_RSV_APPLY: begin
          if (mask_q[idx_q]) begin
            lim_q[idx_q] <= rsv_g_c;
            budget_q     <= budget_q - rsv_g_c;
          end
          idx_q <= idx_q + WIDX_W'(1);
          if (idx_q == WIDX_W'(WHEELS - 1)) begin
            st_q <= S_ROUND;
          end
        end

        S_ROUND: begin
          if (budget_q == '0 || unmet_cnt_c == '0) begin
            st_q <= S_DONE;
          end else begin
            dsum_q  <= dsum_c;
            unmet_q <= unmet_cnt_c;
            total_q <= '0;
            idx_q   <= '0;
            st_q    <= S_WHEEL;
          end
        end

        S_WHEEL: begin
          // lim of this wheel is still its round-start value here
          if (!unmet_vec[idx_q]) begin
            idx_q <= idx_q + WIDX_W'(1);
            if (idx_q == WIDX_W'(WHEELS - 1)) begin
              st_q <= S_ROUND_END;
            end
          end else if (dsum_q != '0) begin
            prod_q <= DIV_N_W'(budget_q) * DIV_N_W'(dem_q[idx_q]);
            st_q   <= S_MUL;
          end else begin
            div_req_q.start <= 1'b1;
            div_req_q.num   <= DIV_N_W'(budget_q);
            div_req_q.den   <= DIV_D_W'(unmet_q);
            st_q            <= S_SHARE_DIV;
          end
        end

        S_MUL: begin
          div_req_q.start <= 1'b1;
          div_req_q.num   <= prod_q;
          div_req_q.den   <= dsum_q;
          st_q            <= S_SHARE_DIV;
        end

        S_SHARE_DIV: begin
          div_req_q.start <= 1'b0;
          if (div_rsp.done) begin
            lim_q[idx_q] <= lim_q[idx_q] + grant_c;
            total_q      <= total_q + (PWR_W+1)'(grant_c);
            idx_q        <= idx_q + WIDX_W'(1);
            if (idx_q == WIDX_W'(WHEELS - 1)) begin
              st_q <= S_ROUND_END;
            end else begin
              st_q <= S_WHEEL;
            end
          end
        end

        S_ROUND_END: begin
          if (total_q == '0) begin
            st_q <= S_DONE;
          end else begin
            budget_q <= (total_q > (PWR_W+1)'(budget_q)) ? '0
                      : budget_q - total_q[PWR_W-1:0];
            rnd_q    <= rnd_q + RND_W'(1);
            if (rnd_q == RND_W'(ROUNDS_C - 1)) begin
              st_q <= S_DONE;
            end else begin
              st_q <= S_ROUND;
            end
          end
        end

        S_DONE: begin
          // load the output register once it is free or being drained
          if (!m_valid_q || m_axis_tready) begin
            m_valid_q <= 1'b1;
            m_data_q  <= {budget_q, lim_q[3], lim_q[2], lim_q[1], lim_q[0]};
            m_user_q  <= applied_q;
            st_q      <= S_IDLE;
          end
        end

        default: begin
          st_q <= S_IDLE;
        end
      endcase
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;
  assign m_axis_tuser  = m_user_q;

`ifndef ASSERT_OFF
  a_lim_within_want: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == S_DONE) |-> (lim_q[0] <= want_q[0] && lim_q[1] <= want_q[1] &&
                          lim_q[2] <= want_q[2] && lim_q[3] <= want_q[3]))
    else $error("granted power exceeds wanted power");

  a_div_done_expected: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_rsp.done |-> (st_q == S_RSV_DIV || st_q == S_RSV_CLAMP ||
                      st_q == S_SHARE_DIV))
    else $error("divider finished outside a wait state");

  a_not_applied_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_valid_q && !m_user_q) |-> (m_data_q[WHEELS*PWR_W-1:0] == '0))
    else $error("limits granted without allocation");

  a_div_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_req_q.start |=> !div_rsp.done)
    else $error("divider result too early");
`endif

endmodule

### sim/tb.sv
module tb;
  import wpba_pkg::*;

  localparam int unsigned ALLOC_ROUNDS   = 4;
  localparam int unsigned NUM_ROUNDS     = (ALLOC_ROUNDS < 1) ? 1 :
                                           (ALLOC_ROUNDS > 8) ? 8 : ALLOC_ROUNDS;
  localparam int unsigned ITEMS_PER_SET  = 112;
  localparam int unsigned WATCHDOG_LIMIT = 4000;
  localparam int unsigned SETTLE_CYCLES  = 16;
  localparam int unsigned FINAL_CYCLES   = 400;

  typedef struct packed {
    logic [PWR_W-1:0]              budget;
    logic [MASK_W-1:0]             mask;
    logic [WHEELS-1:0][PWR_W-1:0]  want;
    logic [WHEELS-1:0][PWR_W-1:0]  demand;
  } alloc_req_t;

  typedef struct packed {
    logic                          applied;
    logic [PWR_W-1:0]              leftover;
    logic [WHEELS-1:0][PWR_W-1:0]  limit;
  } alloc_res_t;

  class alloc_scoreboard;
    logic [PWR_W-1:0] chassis_cap;
    alloc_res_t       expected_q[$];
    int unsigned      errors;
    int unsigned      items_seen;
    int unsigned      results_seen;
    int unsigned      reserve_hits;
    int unsigned      applied_hits;

    function new();
      chassis_cap  = PWR_LIMIT_RST;
      errors       = 0;
      items_seen   = 0;
      results_seen = 0;
      reserve_hits = 0;
      applied_hits = 0;
    endfunction

    function int unsigned pending();
      return expected_q.size();
    endfunction

    // Reserve stage, then demand-proportional (or equal-split) rounds on the round-start budget
    function alloc_res_t allocate(alloc_req_t rq);
      longint unsigned bud, cnt, rsv, dsum, unmet, total, room, g, pl;
      longint unsigned lim[WHEELS];
      alloc_res_t      res;
      bud = rq.budget;
      pl  = chassis_cap;
      cnt = 0;
      res = '0;
      for (int i = 0; i < WHEELS; i++) begin
        lim[i] = 0;
        if (rq.mask[i]) cnt++;
      end
      if (bud == 0 || cnt == 0) begin
        res.leftover = rq.budget;
        return res;
      end
      applied_hits++;
      if (pl != 0 && bud * 40 >= pl * 27) begin
        reserve_hits++;
        rsv = pl / 10;
        if (rsv * cnt > bud) rsv = bud / cnt;
        for (int i = 0; i < WHEELS; i++) begin
          if (rq.mask[i]) begin
            lim[i] = (rsv < rq.want[i]) ? rsv : longint'(rq.want[i]);
            bud -= lim[i];
          end
        end
      end
      for (int r = 0; r < NUM_ROUNDS; r++) begin
        if (bud == 0) break;
        dsum  = 0;
        unmet = 0;
        total = 0;
        for (int i = 0; i < WHEELS; i++) begin
          if (rq.mask[i] && rq.want[i] > lim[i]) begin
            dsum += rq.demand[i];
            unmet++;
          end
        end
        if (unmet == 0) break;
        for (int i = 0; i < WHEELS; i++) begin
          if (rq.mask[i] && rq.want[i] > lim[i]) begin
            room = rq.want[i] - lim[i];
            g = (dsum != 0) ? bud * rq.demand[i] / dsum : bud / unmet;
            if (g > room) g = room;
            lim[i] += g;
            total  += g;
          end
        end
        if (total == 0) break;
        bud = (total > bud) ? 0 : bud - total;
      end
      for (int i = 0; i < WHEELS; i++) res.limit[i] = PWR_W'(lim[i]);
      res.leftover = PWR_W'(bud);
      res.applied  = 1'b1;
      return res;
    endfunction

    function void note_item(alloc_req_t rq);
      items_seen++;
      expected_q.push_back(allocate(rq));
    endfunction

    function void compare_field(string name, longint unsigned exp_v, longint unsigned got_v);
      if (exp_v != got_v) begin
        errors++;
        $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, exp_v, got_v);
      end
    endfunction

    function void check_result(alloc_res_t got);
      alloc_res_t exp_r;
      results_seen++;
      if (expected_q.size() == 0) begin
        errors++;
        $display("%0t: result beat with nothing expected, got %h", $time, got);
        return;
      end
      exp_r = expected_q.pop_front();
      for (int i = 0; i < WHEELS; i++) begin
        compare_field($sformatf("limit_power_%0d", i), exp_r.limit[i], got.limit[i]);
      end
      compare_field("leftover_budget", exp_r.leftover, got.leftover);
      compare_field("applied", exp_r.applied, got.applied);
    endfunction
  endclass

  logic                  clk_i         = 1'b0;
  logic                  rst_ni        = 1'b0;
  logic                  cfg_we_i      = 1'b0;
  logic [PWR_W-1:0]      cfg_wdata_i   = '0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata  = '0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic                  m_axis_tuser;

  alloc_scoreboard sb = new();
  bit              no_idle = 1'b0;
  int unsigned     quiet_cycles = 0;

  wheel_power_budget_allocator_unit #(
    .ROUNDS(ALLOC_ROUNDS)
  ) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  function automatic bit take_break();
    return !no_idle && ($urandom_range(0, 99) < 29);
  endfunction

  function automatic logic [PWR_W-1:0] pick_power();
    int unsigned sel;
    sel = $urandom_range(0, 99);
    if (sel < 10) return '0;
    if (sel < 20) return '1;
    if (sel < 50) return PWR_W'($urandom_range(0, 200));
    return PWR_W'($urandom);
  endfunction

  function automatic alloc_req_t uniform_item(logic [PWR_W-1:0] demand, logic [PWR_W-1:0] want,
                                              logic [MASK_W-1:0] mask, logic [PWR_W-1:0] budget);
    alloc_req_t rq;
    for (int i = 0; i < WHEELS; i++) begin
      rq.demand[i] = demand;
      rq.want[i]   = want;
    end
    rq.mask   = mask;
    rq.budget = budget;
    return rq;
  endfunction

  function automatic alloc_req_t random_item(logic [PWR_W-1:0] pl);
    alloc_req_t  rq;
    int          thr, b;
    int unsigned sel;
    bit          flat;
    rq.mask = ($urandom_range(0, 19) == 0) ? '0 : MASK_W'($urandom_range(1, 15));
    flat = ($urandom_range(0, 9) == 0);
    for (int i = 0; i < WHEELS; i++) begin
      rq.demand[i] = flat ? '0 : pick_power();
      rq.want[i]   = pick_power();
    end
    // aim a good share of budgets at the reserve trigger point
    thr = (int'(pl) * 27 + 39) / 40;
    sel = $urandom_range(0, 99);
    if (sel < 5) begin
      rq.budget = '0;
    end else if (sel < 35) begin
      rq.budget = PWR_W'($urandom);
    end else if (sel < 65) begin
      b = thr + int'($urandom_range(0, 6)) - 3;
      if (b < 0) b = 0;
      if (b > 65535) b = 65535;
      rq.budget = PWR_W'(b);
    end else begin
      rq.budget = PWR_W'($urandom_range(1, 4000));
    end
    return rq;
  endfunction

  task automatic send_item(input alloc_req_t rq);
    while (take_break()) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= IN_DATA_W'(rq);
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_item(rq);
  endtask

  task automatic send_random(input int unsigned n);
    repeat (n) send_item(random_item(sb.chassis_cap));
  endtask

  task automatic drain(input int unsigned settle);
    s_axis_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (settle) @(posedge clk_i);
  endtask

  task automatic write_chassis_cap(input logic [PWR_W-1:0] value);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    sb.chassis_cap = value;
  endtask

  task automatic send_directed();
    alloc_req_t rq;
    send_item(uniform_item('0, '0, '0, '0));
    send_item(uniform_item('1, '1, '1, '0));          // zero budget
    send_item(uniform_item('1, '1, '0, '1));          // no wheel active
    send_item(uniform_item('1, '1, '1, '1));
    for (int i = 0; i < WHEELS; i++) begin
      rq = uniform_item(100, 1000, MASK_W'(1 << i), 5000);
      rq.demand[i] = PWR_W'($urandom);
      send_item(rq);
    end
    send_item(uniform_item('0, 500, '1, 1000));       // equal split
    rq = uniform_item(50, 400, '1, 2000);
    rq.demand[2] = '0;                                // unmet with zero share
    send_item(rq);
    rq = uniform_item(10, 300, '1, 3000);
    rq.want[0] = '0;
    rq.want[3] = '0;
    send_item(rq);
    send_item(uniform_item(10, '0, '1, 3000));        // every wheel met up front
    send_item(uniform_item(20, 1000, '1, 648));       // right on the reserve trigger
    send_item(uniform_item(20, 1000, '1, 647));       // one below it
    send_item(uniform_item(30, 50, '1, 5000));        // want below reserve
    rq = uniform_item(0, '1, '1, 300);
    rq.demand[0] = 1;
    rq.demand[1] = 1000;
    rq.demand[2] = 60000;
    rq.demand[3] = 7;
    send_item(rq);
    send_item(uniform_item(1000, 100, '1, '1));
    send_item(uniform_item(1, '1, '1, 1));
    rq = uniform_item(16'h5555, 16'hAAAA, 4'b0101, 16'hAAAA);
    send_item(rq);
    send_item(uniform_item('1, '1, 4'b1010, '1));
  endtask

  initial begin
    forever begin
      @(posedge clk_i);
      if (m_axis_tvalid && m_axis_tready) begin
        sb.check_result(alloc_res_t'({m_axis_tuser, m_axis_tdata}));
      end
      m_axis_tready <= !take_break();
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: no beat for %0d cycles, %0d results outstanding",
                 $time, quiet_cycles, sb.pending());
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  initial begin
    logic [PWR_W-1:0] settings[7];
    settings[0] = '0;
    settings[1] = '1;
    settings[2] = 1;
    settings[3] = PWR_LIMIT_RST;
    settings[4] = 10;
    settings[5] = PWR_W'($urandom);
    settings[6] = PWR_W'($urandom_range(100, 3000));
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // chassis cap still at its reset value here
    send_directed();
    send_random(ITEMS_PER_SET);
    drain(SETTLE_CYCLES);

    for (int p = 0; p < 7; p++) begin
      write_chassis_cap(settings[p]);
      no_idle = (p == 3);
      send_random(ITEMS_PER_SET);
      drain(SETTLE_CYCLES);
    end
    no_idle = 1'b0;
    drain(FINAL_CYCLES);

    $display("Ran %0d allocations over 8 chassis cap settings: %0d applied, %0d with reserve",
             sb.items_seen, sb.applied_hits, sb.reserve_hits);
    $display("Checked %0d result beats, %0d field mismatches", sb.results_seen, sb.errors);
    if (sb.errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
